/* hdl/otsu_pkg.sv */
// Shared sizes for the Otsu histogram threshold core.
`timescale 1ns / 1ps
package otsu_pkg;
    localparam int BINS       = 100;
    localparam int MAX_ITEMS  = 4096;
    localparam int SCORE_BITS = 16;

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int BIN_W  = $clog2(BINS);
    localparam int SUM_W  = SCORE_BITS + ADDR_W;
    localparam int M_W    = SCORE_BITS + 8;
    localparam int NUM_W  = SUM_W + 8;
    localparam int DEN_A  = (CNT_W > SCORE_BITS) ? CNT_W : SCORE_BITS;
    localparam int DEN_W  = (DEN_A > BIN_W + 1) ? DEN_A : BIN_W + 1;
    localparam int DCNT_W = $clog2(NUM_W + 1);
    localparam int P1_W   = 2 * CNT_W;
    localparam int P2_W   = P1_W + M_W;
    localparam int PH_W   = (P2_W + 1) / 2;
    localparam int PT_W   = P2_W - PH_W;
    localparam int SB_W   = P2_W + M_W;

    // threshold = floor(bin * range / BINS) by reciprocal multiplication
    localparam int TP_W      = BIN_W + SCORE_BITS;
    localparam int THR_SHIFT = TP_W + BIN_W;
    localparam int RCP_W     = THR_SHIFT - BIN_W + 2;
    localparam int PR_W      = TP_W + RCP_W;
    localparam longint unsigned THR_RECIP = ((64'd1 << THR_SHIFT) + BINS - 1) / BINS;
endpackage

/* hdl/otsu_histogram_threshold_core.sv */
// Otsu threshold core: score store, histogram memory, shared divider and split sweep.
`timescale 1ns / 1ps
// Scores load one per cycle while busy is low: start with busy low takes one transaction,
// and a score past the buffer depth is dropped and flagged as overflow. The transaction
// with last set closes the set; busy then rises for the compute. Binning each stored
// score waits on the shared restoring divider, which forms one quotient bit per cycle;
// in the sweep, each bin that splits the set takes two mean divisions plus the multiply
// chain, and the threshold is formed as bin times range, then a reciprocal multiply by
// the bin count. Histogram entries carry valid bits that drop all at once when the
// compute starts, so no clearing pass is needed. The result is on the output ports for
// exactly one cycle, marked by o_valid; the receiver cannot stall it, and busy is
// already low in that cycle so the next set may begin at once.
module otsu_histogram_threshold_core
    import otsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [15:0] i_score,
    input  logic        i_last,
    output logic        busy,
    output logic        o_valid,
    output logic [15:0] o_threshold,
    output logic [6:0]  o_bin_index,
    output logic        o_used_default,
    output logic        o_overflow
);

    typedef enum logic [4:0] {
        S_LOAD, S_START, S_BIN_RD, S_BIN_DV, S_BIN_WAIT, S_BIN_WR,
        S_SW_RD, S_SW_ACC, S_SW_M1, S_SW_M2, S_SW_P1, S_SW_P2, S_SW_P3,
        S_SW_SUM, S_SW_CMP, S_FIN, S_THR_W
    } t_state;

    t_state r_state;

    // set statistics
    logic [CNT_W-1:0]      r_count;
    logic [SUM_W-1:0]      r_total;
    logic [SCORE_BITS-1:0] r_min, r_max, r_range, r_val;
    logic                  r_ovf;

    // walk indexes
    logic [CNT_W-1:0] r_i;
    logic [BIN_W-1:0] r_b, r_bin, r_idx;

    // sweep datapath
    logic [CNT_W-1:0] r_n1, r_n2;
    logic [SUM_W-1:0] r_fore;
    logic [M_W-1:0]   r_m1, r_m2, r_d;
    logic [P1_W-1:0]  r_p1;
    logic [P2_W-1:0]  r_p2;
    logic [M_W+PH_W-1:0] r_pl;
    logic [M_W+PT_W-1:0] r_ph;
    logic [SB_W-1:0]  r_sb, r_best;
    logic             r_found;

    // threshold datapath
    logic [TP_W-1:0]  r_tp;
    logic [PR_W-1:0]  thr_prod;

    // memories
    logic [SCORE_BITS-1:0] r_store [MAX_ITEMS];
    logic [SCORE_BITS-1:0] r_store_q;
    logic [CNT_W-1:0]      r_bcnt [BINS];
    logic [SUM_W-1:0]      r_bsum [BINS];
    logic [CNT_W-1:0]      r_bcnt_q;
    logic [SUM_W-1:0]      r_bsum_q;
    logic [BINS-1:0]       r_bvld;
    logic                  r_bvld_q;

    // divider
    logic [NUM_W-1:0]  r_dv_num;
    logic [DEN_W-1:0]  r_dv_den, r_dv_rem;
    logic [DCNT_W-1:0] r_dv_cnt;
    logic              r_dv_run;

    // result registers
    logic        r_valid, r_dflt, r_ovf_o;
    logic [15:0] r_thr;
    logic [6:0]  r_bidx;

    logic                  accept, store_we, bin_we;
    logic [SCORE_BITS-1:0] score_v, rng_c;
    logic [BIN_W-1:0]      bin_clamped, bin_ra;
    logic [CNT_W-1:0]      bcnt_eff, n1_next;
    logic [SUM_W-1:0]      bsum_eff, fore_next;
    logic                  sw_skip, sw_brk;
    logic                  dv_start;
    logic [NUM_W-1:0]      dv_num_in;
    logic [DEN_W-1:0]      dv_den_in;
    logic [DEN_W:0]        dv_sh, dv_diff;
    logic                  dv_ge;

    assign busy    = (r_state != S_LOAD);
    assign score_v = i_score[SCORE_BITS-1:0];
    assign accept  = start && !busy;
    assign store_we = accept && (r_count < CNT_W'(MAX_ITEMS));
    assign rng_c   = (r_max >= r_min) ? (r_max - r_min) : '0;

    assign bin_clamped = (r_dv_num >= NUM_W'(BINS)) ? BIN_W'(BINS - 1)
                                                    : r_dv_num[BIN_W-1:0];
    assign bin_ra   = (r_state == S_SW_RD) ? r_b : bin_clamped;
    assign bin_we   = (r_state == S_BIN_WR);
    assign bcnt_eff = r_bvld_q ? r_bcnt_q : '0;
    assign bsum_eff = r_bvld_q ? r_bsum_q : '0;
    assign n1_next   = r_n1 + bcnt_eff;
    assign fore_next = r_fore + bsum_eff;
    assign sw_skip   = (n1_next == '0);
    assign sw_brk    = (n1_next == r_count);
    assign thr_prod  = PR_W'(r_tp) * PR_W'(THR_RECIP);

    // pick divider operands per phase
    always_comb begin
        dv_start  = 1'b0;
        dv_num_in = '0;
        dv_den_in = '0;
        case (r_state)
            S_BIN_DV: begin
                dv_start  = 1'b1;
                dv_num_in = NUM_W'(r_store_q) * NUM_W'(BINS);
                dv_den_in = DEN_W'(r_range);
            end
            S_SW_ACC: begin
                dv_start  = !sw_skip && !sw_brk;
                dv_num_in = {fore_next, 8'b0};
                dv_den_in = DEN_W'(n1_next);
            end
            S_SW_M1: begin
                dv_start  = !r_dv_run;
                dv_num_in = {r_total - r_fore, 8'b0};
                dv_den_in = DEN_W'(r_n2);
            end
            default: begin
                dv_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        dv_sh   = {r_dv_rem, r_dv_num[NUM_W-1]};
        dv_diff = dv_sh - {1'b0, r_dv_den};
        dv_ge   = (dv_sh >= {1'b0, r_dv_den});
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_run <= 1'b0;
        end else if (dv_start) begin
            r_dv_num <= dv_num_in;
            r_dv_den <= dv_den_in;
            r_dv_rem <= '0;
            r_dv_cnt <= DCNT_W'(NUM_W);
            r_dv_run <= 1'b1;
        end else if (r_dv_run) begin
            r_dv_rem <= dv_ge ? dv_diff[DEN_W-1:0] : dv_sh[DEN_W-1:0];
            r_dv_num <= {r_dv_num[NUM_W-2:0], dv_ge};
            r_dv_cnt <= r_dv_cnt - DCNT_W'(1);
            if (r_dv_cnt == DCNT_W'(1)) begin
                r_dv_run <= 1'b0;
            end
        end
    end

    // score store
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_count[ADDR_W-1:0]] <= score_v;
        end
        r_store_q <= r_store[r_i[ADDR_W-1:0]];
    end

    // histogram memory
    always_ff @(posedge i_clk) begin
        if (bin_we) begin
            r_bcnt[r_bin] <= bcnt_eff + CNT_W'(1);
            r_bsum[r_bin] <= bsum_eff + SUM_W'(r_val);
        end
        r_bcnt_q <= r_bcnt[bin_ra];
        r_bsum_q <= r_bsum[bin_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_total <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_ovf   <= 1'b0;
            r_bvld  <= '0;
            r_valid <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_valid  <= 1'b0;
            r_bvld_q <= r_bvld[bin_ra];
            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (store_we) begin
                            r_count <= r_count + CNT_W'(1);
                            r_total <= r_total + SUM_W'(score_v);
                            if (score_v < r_min) r_min <= score_v;
                            if (score_v > r_max) r_max <= score_v;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last) r_state <= S_START;
                    end
                end
                S_START: begin
                    r_range <= rng_c;
                    r_bvld  <= '0;
                    r_found <= 1'b0;
                    r_best  <= '0;
                    r_idx   <= '0;
                    r_n1    <= '0;
                    r_fore  <= '0;
                    r_b     <= '0;
                    r_i     <= '0;
                    r_state <= (rng_c == '0) ? S_FIN : S_BIN_RD;
                end
                S_BIN_RD: r_state <= S_BIN_DV;
                S_BIN_DV: begin
                    r_val   <= r_store_q;
                    r_state <= S_BIN_WAIT;
                end
                S_BIN_WAIT: begin
                    if (!r_dv_run) begin
                        r_bin   <= bin_clamped;
                        r_state <= S_BIN_WR;
                    end
                end
                S_BIN_WR: begin
                    r_bvld[r_bin] <= 1'b1;
                    if (r_i == r_count - CNT_W'(1)) begin
                        r_state <= S_SW_RD;
                    end else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_BIN_RD;
                    end
                end
                S_SW_RD: r_state <= S_SW_ACC;
                S_SW_ACC: begin
                    r_n1 <= n1_next;
                    if (sw_skip) begin
                        // empty lower class: move on
                        if (r_b == BIN_W'(BINS - 1)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_b     <= r_b + BIN_W'(1);
                            r_state <= S_SW_RD;
                        end
                    end else if (sw_brk) begin
                        r_state <= S_FIN;
                    end else begin
                        r_n2    <= r_count - n1_next;
                        r_fore  <= fore_next;
                        r_state <= S_SW_M1;
                    end
                end
                S_SW_M1: begin
                    if (!r_dv_run) begin
                        r_m1    <= r_dv_num[M_W-1:0];
                        r_state <= S_SW_M2;
                    end
                end
                S_SW_M2: begin
                    if (!r_dv_run) begin
                        r_m2    <= r_dv_num[M_W-1:0];
                        r_state <= S_SW_P1;
                    end
                end
                S_SW_P1: begin
                    r_d     <= (r_m1 >= r_m2) ? (r_m1 - r_m2) : (r_m2 - r_m1);
                    r_p1    <= P1_W'(r_n1) * P1_W'(r_n2);
                    r_state <= S_SW_P2;
                end
                S_SW_P2: begin
                    r_p2    <= P2_W'(r_p1) * P2_W'(r_d);
                    r_state <= S_SW_P3;
                end
                S_SW_P3: begin
                    r_pl <= (M_W + PH_W)'(r_p2[PH_W-1:0]) * (M_W + PH_W)'(r_d);
                    r_ph <= (M_W + PT_W)'(r_p2[P2_W-1:PH_W]) * (M_W + PT_W)'(r_d);
                    r_state <= S_SW_SUM;
                end
                S_SW_SUM: begin
                    r_sb    <= (SB_W'(r_ph) << PH_W) + SB_W'(r_pl);
                    r_state <= S_SW_CMP;
                end
                S_SW_CMP: begin
                    // keep the first strictly largest split
                    if (!r_found || (r_sb > r_best)) begin
                        r_found <= 1'b1;
                        r_best  <= r_sb;
                        r_idx   <= r_b;
                    end
                    if (r_b == BIN_W'(BINS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_b     <= r_b + BIN_W'(1);
                        r_state <= S_SW_RD;
                    end
                end
                S_FIN: begin
                    if (r_found) begin
                        r_tp    <= TP_W'(r_idx) * TP_W'(r_range);
                        r_state <= S_THR_W;
                    end else begin
                        r_thr   <= 16'(r_range >> 1);
                        r_bidx  <= '0;
                        r_dflt  <= 1'b1;
                        r_ovf_o <= r_ovf;
                        r_valid <= 1'b1;
                        r_count <= '0;
                        r_total <= '0;
                        r_min   <= '1;
                        r_max   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                S_THR_W: begin
                    r_thr   <= thr_prod[THR_SHIFT+15:THR_SHIFT];
                    r_bidx  <= 7'(r_idx);
                    r_dflt  <= 1'b0;
                    r_ovf_o <= r_ovf;
                    r_valid <= 1'b1;
                    r_count <= '0;
                    r_total <= '0;
                    r_min   <= '1;
                    r_max   <= '0;
                    r_ovf   <= 1'b0;
                    r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_threshold    = r_thr;
    assign o_bin_index    = r_bidx;
    assign o_used_default = r_dflt;
    assign o_overflow     = r_ovf_o;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_default_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_used_default) |-> (o_bin_index == 7'd0))
        else $error("default result with nonzero bin");
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !r_dv_run) else $error("divider running while idle");
    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_we |-> (r_count < CNT_W'(MAX_ITEMS))) else $error("store overrun");
`endif

endmodule

/* tb/otsu_histogram_threshold_core_tb.sv */
// Testbench for the Otsu histogram threshold core: directed and random data sets checked against a predictor.
`timescale 1ns / 1ps
module otsu_histogram_threshold_core_tb;
    import otsu_pkg::*;

    localparam int STALL_LIMIT = 400000;   // cycles with no transaction or result before giving up
    localparam int DRAIN_CYCLES = 20000;   // settle time after the last result
    localparam int RANDOM_ITEMS = 1500;

    typedef struct {
        logic [15:0] score;
        logic        last;
    } t_score_item;

    typedef struct packed {
        logic [15:0] threshold;
        logic [6:0]  bin_index;
        logic        used_default;
        logic        overflow;
    } t_split_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [15:0] i_score = '0;
    logic        i_last = 1'b0;
    logic        busy;
    logic        o_valid;
    logic [15:0] o_threshold;
    logic [6:0]  o_bin_index;
    logic        o_used_default;
    logic        o_overflow;

    otsu_histogram_threshold_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_score        (i_score),
        .i_last         (i_last),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_threshold    (o_threshold),
        .o_bin_index    (o_bin_index),
        .o_used_default (o_used_default),
        .o_overflow     (o_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Pending scores, expected splits, and the predictor's copy of the set state.
    t_score_item     pending_scores[$];
    t_split_result   expected_splits[$];
    int unsigned     set_values[$];
    longint unsigned set_sum = 0;
    int unsigned     set_min = 32'hFFFF;
    int unsigned     set_max = 0;
    bit              set_dropped = 1'b0;
    bit              took_score = 1'b0;
    bit              fail_seen = 1'b0;
    bit              no_gaps = 1'b0;
    int              gap_left = 0;
    int              quiet_cycles = 0;

    // Histogram the stored set, sweep for the best split, and reset the set state.
    function automatic t_split_result close_set();
        longint unsigned hist_cnt[BINS];
        longint unsigned hist_sum[BINS];
        longint unsigned range, bin, n_lo, n_hi, fore, mean_lo, mean_hi, mean_gap, idx;
        logic [127:0]    score_sb, best_sb;
        bit              found;
        t_split_result   res;
        range = (set_max >= set_min) ? set_max - set_min : 0;
        found = 1'b0;
        best_sb = '0;
        idx = 0;
        for (int b = 0; b < BINS; b++) begin
            hist_cnt[b] = 0;
            hist_sum[b] = 0;
        end
        if (range != 0) begin
            foreach (set_values[k]) begin
                bin = (longint'(set_values[k]) * BINS) / range;
                if (bin > BINS - 1) bin = BINS - 1;
                hist_cnt[bin]++;
                hist_sum[bin] += set_values[k];
            end
            n_lo = 0;
            fore = 0;
            for (int b = 0; b < BINS; b++) begin
                n_lo += hist_cnt[b];
                if (n_lo == 0) continue;
                n_hi = set_values.size() - n_lo;
                if (n_hi == 0) break;
                fore += hist_sum[b];
                mean_lo = (fore << 8) / n_lo;
                mean_hi = ((set_sum - fore) << 8) / n_hi;
                mean_gap = (mean_lo >= mean_hi) ? mean_lo - mean_hi : mean_hi - mean_lo;
                score_sb = 128'(n_lo * n_hi) * 128'(mean_gap) * 128'(mean_gap);
                if (!found || score_sb > best_sb) begin
                    found = 1'b1;
                    best_sb = score_sb;
                    idx = b;
                end
            end
        end
        res.threshold    = found ? 16'((idx * range) / BINS) : 16'(range / 2);
        res.bin_index    = found ? 7'(idx) : 7'd0;
        res.used_default = !found;
        res.overflow     = set_dropped;
        set_values.delete();
        set_sum = 0;
        set_min = 32'hFFFF;
        set_max = 0;
        set_dropped = 1'b0;
        return res;
    endfunction

    // Take one accepted score into the set; close the set on last.
    task automatic absorb_score(input logic [15:0] s, input logic l);
        if (set_values.size() < MAX_ITEMS) begin
            set_values = {set_values, s};
            set_sum += s;
            if (s < set_min) set_min = s;
            if (s > set_max) set_max = s;
        end else begin
            set_dropped = 1'b1;
        end
        if (l) expected_splits = {expected_splits, close_set()};
    endtask

    task automatic queue_score(input int unsigned s, input bit l);
        t_score_item it;
        it.score = 16'(s);
        it.last = l;
        pending_scores = {pending_scores, it};
    endtask

    // Random set: width of the spread decides how often values share bins.
    task automatic queue_random_set(input int n);
        int unsigned base, spread;
        case ($urandom_range(0, 3))
            0: begin base = 0; spread = 65535; end
            1: begin base = $urandom_range(0, 65000); spread = $urandom_range(1, 400); end
            2: begin base = $urandom_range(0, 60000); spread = $urandom_range(1, 5000); end
            default: begin base = $urandom_range(0, 65535); spread = 0; end
        endcase
        for (int k = 0; k < n; k++) begin
            queue_score((base + $urandom_range(0, spread)) & 16'hFFFF, k == n - 1);
        end
    endtask

    // Driver: inputs change on the falling edge; hold start until the transaction lands.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (took_score) begin
                if (pending_scores[0].last) no_gaps = ($urandom_range(0, 3) == 0);
                void'(pending_scores.pop_front());
                took_score = 1'b0;
                gap_left = no_gaps ? 0 : $urandom_range(0, 19);
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_scores.size() > 0) begin
                start   <= 1'b1;
                i_score <= pending_scores[0].score;
                i_last  <= pending_scores[0].last;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: sample on the rising edge, predict accepted transactions, check results.
    always @(posedge i_clk) begin
        t_split_result exp_r;
        if (i_rst_n) begin
            quiet_cycles++;
            if (start && !busy) begin
                absorb_score(i_score, i_last);
                took_score = 1'b1;
                quiet_cycles = 0;
            end
            if (o_valid) begin
                quiet_cycles = 0;
                if (expected_splits.size() == 0) begin
                    $display("%0t: unexpected result thr=%0d bin=%0d dflt=%0b ovf=%0b",
                             $time, o_threshold, o_bin_index, o_used_default, o_overflow);
                    fail_seen = 1'b1;
                end else begin
                    exp_r = expected_splits.pop_front();
                    if (o_threshold !== exp_r.threshold) begin
                        $display("%0t: threshold expected %0d actual %0d",
                                 $time, exp_r.threshold, o_threshold);
                        fail_seen = 1'b1;
                    end
                    if (o_bin_index !== exp_r.bin_index) begin
                        $display("%0t: bin_index expected %0d actual %0d",
                                 $time, exp_r.bin_index, o_bin_index);
                        fail_seen = 1'b1;
                    end
                    if (o_used_default !== exp_r.used_default) begin
                        $display("%0t: used_default expected %0b actual %0b",
                                 $time, exp_r.used_default, o_used_default);
                        fail_seen = 1'b1;
                    end
                    if (o_overflow !== exp_r.overflow) begin
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, exp_r.overflow, o_overflow);
                        fail_seen = 1'b1;
                    end
                end
            end
            // Watchdog: a long compute is fine, total silence is not.
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int queued;
        int n;
        // Directed sets: single value, equal values, extremes, a one-step range
        // that lands every value in the top bin, and a clean two-cluster split.
        queue_score(16'h1234, 1'b1);
        queue_score(777, 1'b0); queue_score(777, 1'b0); queue_score(777, 1'b1);
        queue_score(0, 1'b0); queue_score(16'hFFFF, 1'b1);
        queue_score(0, 1'b0); queue_score(16'hFFFF, 1'b0); queue_score(16'h8000, 1'b1);
        queue_score(50000, 1'b0); queue_score(50001, 1'b1);
        queue_score(16'hFFFF, 1'b0); queue_score(16'hFFFF, 1'b1);
        for (int k = 0; k < 8; k++) queue_score((k < 4) ? 100 + k : 60000 + k, k == 7);

        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
            queue_random_set(n);
            queued += n;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_scores.size() == 0 && expected_splits.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!fail_seen && expected_splits.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* otsu_histogram_threshold_core.f */
hdl/otsu_pkg.sv
hdl/otsu_histogram_threshold_core.sv
tb/otsu_histogram_threshold_core_tb.sv
